>>> src/rtch_pkg.sv
package rtch_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int TAG_WIDTH   = 8;

    localparam int PROG_LEN  = 30;
    localparam int PC_W      = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DET_THR  = 3'd6;

    typedef logic signed [63:0] t_ival;

    localparam t_ival ILIM = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef enum logic [4:0] {
        OPD_DX, OPD_DY, OPD_DZ, OPD_OX, OPD_OY, OPD_OZ,
        OPD_E1X, OPD_E1Y, OPD_E1Z, OPD_E2X, OPD_E2Y, OPD_E2Z,
        OPD_TVX, OPD_TVY, OPD_TVZ, OPD_PVX, OPD_PVY, OPD_PVZ,
        OPD_QVX, OPD_QVY, OPD_QVZ, OPD_T, OPD_ONE
    } t_opnd;

    typedef enum logic [3:0] {
        DST_PV0, DST_PV1, DST_PV2, DST_DET, DST_QV0, DST_QV1, DST_QV2,
        DST_UN, DST_VN, DST_TN, DST_PX, DST_PY, DST_PZ
    } t_dst;

    typedef struct packed {
        t_opnd a;
        t_opnd b;
        logic  neg;
        logic  first;
        t_dst  dst;
        logic  last;
    } t_uop;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ISSUE, ST_WAIT, ST_DET, ST_TEST, ST_DIV, ST_BEST, ST_FIN
    } t_state;

    function automatic t_uop mk(input t_opnd a, input t_opnd b, input logic neg,
                                input logic first, input t_dst dst, input logic last);
        t_uop u;
        u.a     = a;
        u.b     = b;
        u.neg   = neg;
        u.first = first;
        u.dst   = dst;
        u.last  = last;
        return u;
    endfunction

    function automatic t_uop prog_at(input logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            5'd0:  u = mk(OPD_DY,  OPD_E2Z, 1'b0, 1'b1, DST_PV0, 1'b0);
            5'd1:  u = mk(OPD_DZ,  OPD_E2Y, 1'b1, 1'b0, DST_PV0, 1'b0);
            5'd2:  u = mk(OPD_DZ,  OPD_E2X, 1'b0, 1'b1, DST_PV1, 1'b0);
            5'd3:  u = mk(OPD_DX,  OPD_E2Z, 1'b1, 1'b0, DST_PV1, 1'b0);
            5'd4:  u = mk(OPD_DX,  OPD_E2Y, 1'b0, 1'b1, DST_PV2, 1'b0);
            5'd5:  u = mk(OPD_DY,  OPD_E2X, 1'b1, 1'b0, DST_PV2, 1'b0);
            5'd6:  u = mk(OPD_E1X, OPD_PVX, 1'b0, 1'b1, DST_DET, 1'b0);
            5'd7:  u = mk(OPD_E1Y, OPD_PVY, 1'b0, 1'b0, DST_DET, 1'b0);
            5'd8:  u = mk(OPD_E1Z, OPD_PVZ, 1'b0, 1'b0, DST_DET, 1'b1);
            5'd9:  u = mk(OPD_TVY, OPD_E1Z, 1'b0, 1'b1, DST_QV0, 1'b0);
            5'd10: u = mk(OPD_TVZ, OPD_E1Y, 1'b1, 1'b0, DST_QV0, 1'b0);
            5'd11: u = mk(OPD_TVZ, OPD_E1X, 1'b0, 1'b1, DST_QV1, 1'b0);
            5'd12: u = mk(OPD_TVX, OPD_E1Z, 1'b1, 1'b0, DST_QV1, 1'b0);
            5'd13: u = mk(OPD_TVX, OPD_E1Y, 1'b0, 1'b1, DST_QV2, 1'b0);
            5'd14: u = mk(OPD_TVY, OPD_E1X, 1'b1, 1'b0, DST_QV2, 1'b0);
            5'd15: u = mk(OPD_TVX, OPD_PVX, 1'b0, 1'b1, DST_UN,  1'b0);
            5'd16: u = mk(OPD_TVY, OPD_PVY, 1'b0, 1'b0, DST_UN,  1'b0);
            5'd17: u = mk(OPD_TVZ, OPD_PVZ, 1'b0, 1'b0, DST_UN,  1'b0);
            5'd18: u = mk(OPD_DX,  OPD_QVX, 1'b0, 1'b1, DST_VN,  1'b0);
            5'd19: u = mk(OPD_DY,  OPD_QVY, 1'b0, 1'b0, DST_VN,  1'b0);
            5'd20: u = mk(OPD_DZ,  OPD_QVZ, 1'b0, 1'b0, DST_VN,  1'b0);
            5'd21: u = mk(OPD_E2X, OPD_QVX, 1'b0, 1'b1, DST_TN,  1'b0);
            5'd22: u = mk(OPD_E2Y, OPD_QVY, 1'b0, 1'b0, DST_TN,  1'b0);
            5'd23: u = mk(OPD_E2Z, OPD_QVZ, 1'b0, 1'b0, DST_TN,  1'b1);
            5'd24: u = mk(OPD_DX,  OPD_T,   1'b0, 1'b1, DST_PX,  1'b0);
            5'd25: u = mk(OPD_OX,  OPD_ONE, 1'b0, 1'b0, DST_PX,  1'b0);
            5'd26: u = mk(OPD_DY,  OPD_T,   1'b0, 1'b1, DST_PY,  1'b0);
            5'd27: u = mk(OPD_OY,  OPD_ONE, 1'b0, 1'b0, DST_PY,  1'b0);
            5'd28: u = mk(OPD_DZ,  OPD_T,   1'b0, 1'b1, DST_PZ,  1'b0);
            5'd29: u = mk(OPD_OZ,  OPD_ONE, 1'b0, 1'b0, DST_PZ,  1'b1);
            default: u = mk(OPD_ONE, OPD_ONE, 1'b0, 1'b1, DST_PZ, 1'b1);
        endcase
        return u;
    endfunction

endpackage

>>> src/rtch_tri_if.sv
interface rtch_tri_if #(
    parameter int COORD_WIDTH = rtch_pkg::COORD_WIDTH,
    parameter int TAG_WIDTH   = rtch_pkg::TAG_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] v0_x;
    logic signed [COORD_WIDTH-1:0] v0_y;
    logic signed [COORD_WIDTH-1:0] v0_z;
    logic signed [COORD_WIDTH-1:0] v1_x;
    logic signed [COORD_WIDTH-1:0] v1_y;
    logic signed [COORD_WIDTH-1:0] v1_z;
    logic signed [COORD_WIDTH-1:0] v2_x;
    logic signed [COORD_WIDTH-1:0] v2_y;
    logic signed [COORD_WIDTH-1:0] v2_z;
    logic [TAG_WIDTH-1:0]          object_tag;
    logic                          end_of_set;

    modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                    object_tag, end_of_set, input ready);
    modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  object_tag, end_of_set, output ready);
endinterface

>>> src/rtch_res_if.sv
interface rtch_res_if #(
    parameter int COORD_WIDTH = rtch_pkg::COORD_WIDTH,
    parameter int TAG_WIDTH   = rtch_pkg::TAG_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic                          tri_hit;
    logic signed [COORD_WIDTH-1:0] tri_distance;
    logic                          best_found;
    logic signed [COORD_WIDTH-1:0] best_distance;
    logic signed [COORD_WIDTH-1:0] best_x;
    logic signed [COORD_WIDTH-1:0] best_y;
    logic signed [COORD_WIDTH-1:0] best_z;
    logic [TAG_WIDTH-1:0]          best_object;

    modport source (output valid, tri_hit, tri_distance, best_found, best_distance,
                    best_x, best_y, best_z, best_object, input ready);
    modport sink (input valid, tri_hit, tri_distance, best_found, best_distance,
                  best_x, best_y, best_z, best_object, output ready);
endinterface

>>> src/ray_triangle_closest_hit.sv
// Each item runs through the determinant test, then the hit test; a hit starts the
// division for t (which ends early if t saturates), and a hit that becomes the new
// closest one also computes the hit point. The result then waits out any output stall.
// Each multiply runs on the one shared 32x32 multiplier (four partial products). One
// item at a time: the next item can be accepted in the cycle after the result loads.
// Reset (synchronous, active low) restores the ray registers and clears the best hit.
module ray_triangle_closest_hit #(
    parameter int COORD_WIDTH = rtch_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = rtch_pkg::FRAC_BITS,
    parameter int TAG_WIDTH   = rtch_pkg::TAG_WIDTH
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_cfg_we,
    input  logic [rtch_pkg::CFG_IDX_W-1:0]                  i_cfg_idx,
    input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] i_cfg_data,
    rtch_tri_if.sink                                        i_tri,
    rtch_res_if.source                                      o_res
);

    localparam int CW = COORD_WIDTH;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] DIR_Z_RST =
        {{(CW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam rtch_pkg::t_ival ONE_I = rtch_pkg::t_ival'(64'd1 << FRAC_BITS);
    localparam rtch_pkg::t_ival CMAX_I = rtch_pkg::t_ival'(CMAX);
    localparam rtch_pkg::t_ival CMIN_I = -CMAX_I - 64'sd1;

    rtch_pkg::t_state r_state, n_state;

    logic signed [CW-1:0] r_org [3];
    logic signed [CW-1:0] r_dir [3];
    logic [31:0]          r_thr;

    rtch_pkg::t_ival r_e1 [3];
    rtch_pkg::t_ival r_e2 [3];
    rtch_pkg::t_ival r_tv [3];
    rtch_pkg::t_ival r_pv [3];
    rtch_pkg::t_ival r_qv [3];
    rtch_pkg::t_ival r_pt [3];
    rtch_pkg::t_ival r_det, r_un, r_vn, r_tn, r_acc;
    logic [TAG_WIDTH-1:0] r_tag;
    logic                 r_eos;
    logic                 r_hit;
    logic                 r_upd;
    logic signed [CW-1:0] r_t;
    logic [rtch_pkg::PC_W-1:0] r_pc;

    logic                 r_bvalid;
    logic signed [CW-1:0] r_bdist, r_bx, r_by, r_bz;
    logic [TAG_WIDTH-1:0] r_btag;

    logic                 r_ovalid;
    logic                 r_ohit;
    logic signed [CW-1:0] r_odist, r_obdist, r_obx, r_oby, r_obz;
    logic                 r_obfound;
    logic [TAG_WIDTH-1:0] r_obtag;

    rtch_pkg::t_uop  w_uop;
    rtch_pkg::t_ival w_opa, w_opb, w_base, w_p, w_sat;
    logic signed [64:0] w_sum;
    logic            w_mul_start, w_mul_done;
    rtch_pkg::t_ival w_mul_p;
    logic            w_div_start, w_div_done;
    logic signed [CW-1:0] w_div_q;
    logic [63:0]     w_dm;
    rtch_pkg::t_ival w_un, w_vn, w_tn;
    logic            w_det_ok, w_hit, w_upd, w_load, w_accept;
    logic                 w_nb_valid;
    logic signed [CW-1:0] w_nb_dist, w_nb_x, w_nb_y, w_nb_z;
    logic [TAG_WIDTH-1:0] w_nb_tag;

    function automatic rtch_pkg::t_ival ext(input logic signed [CW-1:0] v);
        return rtch_pkg::t_ival'(v);
    endfunction

    function automatic logic signed [CW-1:0] clamp_cw(input rtch_pkg::t_ival v);
        if (v > CMAX_I) begin
            return CMAX;
        end else if (v < CMIN_I) begin
            return CMIN_I[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    rtch_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_opa),
        .i_b     (w_opb),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    rtch_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_n     (64'(w_tn)),
        .i_d     (w_dm),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    assign w_uop    = rtch_pkg::prog_at(r_pc);
    assign w_accept = i_tri.valid && i_tri.ready;

    always_comb begin
        case (w_uop.a)
            rtch_pkg::OPD_DX:  w_opa = ext(r_dir[0]);
            rtch_pkg::OPD_DY:  w_opa = ext(r_dir[1]);
            rtch_pkg::OPD_DZ:  w_opa = ext(r_dir[2]);
            rtch_pkg::OPD_OX:  w_opa = ext(r_org[0]);
            rtch_pkg::OPD_OY:  w_opa = ext(r_org[1]);
            rtch_pkg::OPD_OZ:  w_opa = ext(r_org[2]);
            rtch_pkg::OPD_E1X: w_opa = r_e1[0];
            rtch_pkg::OPD_E1Y: w_opa = r_e1[1];
            rtch_pkg::OPD_E1Z: w_opa = r_e1[2];
            rtch_pkg::OPD_E2X: w_opa = r_e2[0];
            rtch_pkg::OPD_E2Y: w_opa = r_e2[1];
            rtch_pkg::OPD_E2Z: w_opa = r_e2[2];
            rtch_pkg::OPD_TVX: w_opa = r_tv[0];
            rtch_pkg::OPD_TVY: w_opa = r_tv[1];
            rtch_pkg::OPD_TVZ: w_opa = r_tv[2];
            default:           w_opa = ONE_I;
        endcase
        case (w_uop.b)
            rtch_pkg::OPD_E1X: w_opb = r_e1[0];
            rtch_pkg::OPD_E1Y: w_opb = r_e1[1];
            rtch_pkg::OPD_E1Z: w_opb = r_e1[2];
            rtch_pkg::OPD_E2X: w_opb = r_e2[0];
            rtch_pkg::OPD_E2Y: w_opb = r_e2[1];
            rtch_pkg::OPD_E2Z: w_opb = r_e2[2];
            rtch_pkg::OPD_PVX: w_opb = r_pv[0];
            rtch_pkg::OPD_PVY: w_opb = r_pv[1];
            rtch_pkg::OPD_PVZ: w_opb = r_pv[2];
            rtch_pkg::OPD_QVX: w_opb = r_qv[0];
            rtch_pkg::OPD_QVY: w_opb = r_qv[1];
            rtch_pkg::OPD_QVZ: w_opb = r_qv[2];
            rtch_pkg::OPD_T:   w_opb = ext(r_t);
            default:           w_opb = ONE_I;
        endcase
    end

    assign w_base = w_uop.first ? '0 : r_acc;
    assign w_p    = w_uop.neg ? -w_mul_p : w_mul_p;
    assign w_sum  = {w_base[63], w_base} + {w_p[63], w_p};
    assign w_sat  = (w_sum > 65'(rtch_pkg::ILIM)) ? rtch_pkg::ILIM :
                    (w_sum < -65'(rtch_pkg::ILIM)) ? -rtch_pkg::ILIM : w_sum[63:0];

    assign w_dm     = r_det[63] ? 64'(-r_det) : 64'(r_det);
    assign w_un     = r_det[63] ? -r_un : r_un;
    assign w_vn     = r_det[63] ? -r_vn : r_vn;
    assign w_tn     = r_det[63] ? -r_tn : r_tn;
    assign w_det_ok = (r_det != '0) && (w_dm >= {32'b0, r_thr});
    assign w_hit    = !w_un[63] && (64'(w_un) <= w_dm) && !w_vn[63] &&
                      (64'(w_un) + 64'(w_vn) <= w_dm) && !w_tn[63];
    assign w_upd    = r_hit && (!r_bvalid || (r_t < r_bdist));
    assign w_load   = !r_ovalid || o_res.ready;

    assign w_nb_valid = r_upd ? 1'b1 : r_bvalid;
    assign w_nb_dist  = r_upd ? r_t : r_bdist;
    assign w_nb_x     = r_upd ? clamp_cw(r_pt[0]) : r_bx;
    assign w_nb_y     = r_upd ? clamp_cw(r_pt[1]) : r_by;
    assign w_nb_z     = r_upd ? clamp_cw(r_pt[2]) : r_bz;
    assign w_nb_tag   = r_upd ? r_tag : r_btag;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rtch_pkg::ST_IDLE:  if (w_accept) n_state = rtch_pkg::ST_ISSUE;
            rtch_pkg::ST_ISSUE: n_state = rtch_pkg::ST_WAIT;
            rtch_pkg::ST_WAIT: begin
                if (w_mul_done) begin
                    if (!w_uop.last) begin
                        n_state = rtch_pkg::ST_ISSUE;
                    end else if (w_uop.dst == rtch_pkg::DST_DET) begin
                        n_state = rtch_pkg::ST_DET;
                    end else if (w_uop.dst == rtch_pkg::DST_TN) begin
                        n_state = rtch_pkg::ST_TEST;
                    end else begin
                        n_state = rtch_pkg::ST_FIN;
                    end
                end
            end
            rtch_pkg::ST_DET:
                n_state = w_det_ok ? rtch_pkg::ST_ISSUE : rtch_pkg::ST_BEST;
            rtch_pkg::ST_TEST:
                n_state = w_hit ? rtch_pkg::ST_DIV : rtch_pkg::ST_BEST;
            rtch_pkg::ST_DIV:   if (w_div_done) n_state = rtch_pkg::ST_BEST;
            rtch_pkg::ST_BEST:
                n_state = w_upd ? rtch_pkg::ST_ISSUE : rtch_pkg::ST_FIN;
            rtch_pkg::ST_FIN:   if (w_load) n_state = rtch_pkg::ST_IDLE;
            default:            n_state = rtch_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_tri.ready = (r_state == rtch_pkg::ST_IDLE);
        w_mul_start = (r_state == rtch_pkg::ST_ISSUE);
        w_div_start = (r_state == rtch_pkg::ST_TEST) && w_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rtch_pkg::ST_IDLE;
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= DIR_Z_RST;
            r_thr    <= 32'd1;
            r_bvalid <= 1'b0;
            r_bdist  <= CMAX;
            r_bx     <= CMAX;
            r_by     <= CMAX;
            r_bz     <= CMAX;
            r_btag   <= '0;
            r_ovalid <= 1'b0;
            r_pc     <= '0;
            r_hit    <= 1'b0;
            r_upd    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rtch_pkg::CFG_ORIGIN_X: r_org[0] <= i_cfg_data[CW-1:0];
                    rtch_pkg::CFG_ORIGIN_Y: r_org[1] <= i_cfg_data[CW-1:0];
                    rtch_pkg::CFG_ORIGIN_Z: r_org[2] <= i_cfg_data[CW-1:0];
                    rtch_pkg::CFG_DIR_X:    r_dir[0] <= i_cfg_data[CW-1:0];
                    rtch_pkg::CFG_DIR_Y:    r_dir[1] <= i_cfg_data[CW-1:0];
                    rtch_pkg::CFG_DIR_Z:    r_dir[2] <= i_cfg_data[CW-1:0];
                    rtch_pkg::CFG_DET_THR:  r_thr    <= i_cfg_data[31:0];
                    default: ;
                endcase
            end

            if ((r_state == rtch_pkg::ST_FIN) && w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                rtch_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_e1[0] <= ext(i_tri.v1_x) - ext(i_tri.v0_x);
                        r_e1[1] <= ext(i_tri.v1_y) - ext(i_tri.v0_y);
                        r_e1[2] <= ext(i_tri.v1_z) - ext(i_tri.v0_z);
                        r_e2[0] <= ext(i_tri.v2_x) - ext(i_tri.v0_x);
                        r_e2[1] <= ext(i_tri.v2_y) - ext(i_tri.v0_y);
                        r_e2[2] <= ext(i_tri.v2_z) - ext(i_tri.v0_z);
                        r_tv[0] <= ext(r_org[0]) - ext(i_tri.v0_x);
                        r_tv[1] <= ext(r_org[1]) - ext(i_tri.v0_y);
                        r_tv[2] <= ext(r_org[2]) - ext(i_tri.v0_z);
                        r_tag   <= i_tri.object_tag;
                        r_eos   <= i_tri.end_of_set;
                        r_pc    <= '0;
                        r_hit   <= 1'b0;
                        r_upd   <= 1'b0;
                        r_t     <= CMAX;
                    end
                end
                rtch_pkg::ST_WAIT: begin
                    if (w_mul_done) begin
                        r_acc <= w_sat;
                        r_pc  <= r_pc + 1'b1;
                        case (w_uop.dst)
                            rtch_pkg::DST_PV0: r_pv[0] <= w_sat;
                            rtch_pkg::DST_PV1: r_pv[1] <= w_sat;
                            rtch_pkg::DST_PV2: r_pv[2] <= w_sat;
                            rtch_pkg::DST_DET: r_det   <= w_sat;
                            rtch_pkg::DST_QV0: r_qv[0] <= w_sat;
                            rtch_pkg::DST_QV1: r_qv[1] <= w_sat;
                            rtch_pkg::DST_QV2: r_qv[2] <= w_sat;
                            rtch_pkg::DST_UN:  r_un    <= w_sat;
                            rtch_pkg::DST_VN:  r_vn    <= w_sat;
                            rtch_pkg::DST_TN:  r_tn    <= w_sat;
                            rtch_pkg::DST_PX:  r_pt[0] <= w_sat;
                            rtch_pkg::DST_PY:  r_pt[1] <= w_sat;
                            default:           r_pt[2] <= w_sat;
                        endcase
                    end
                end
                rtch_pkg::ST_TEST: r_hit <= w_hit;
                rtch_pkg::ST_DIV:  if (w_div_done) r_t <= w_div_q;
                rtch_pkg::ST_BEST: r_upd <= w_upd;
                rtch_pkg::ST_FIN: begin
                    if (w_load) begin
                        r_ohit    <= r_hit;
                        r_odist   <= r_t;
                        r_obfound <= w_nb_valid;
                        r_obdist  <= w_nb_dist;
                        r_obx     <= w_nb_x;
                        r_oby     <= w_nb_y;
                        r_obz     <= w_nb_z;
                        r_obtag   <= w_nb_tag;
                        if (r_eos) begin
                            r_bvalid <= 1'b0;
                            r_bdist  <= CMAX;
                            r_bx     <= CMAX;
                            r_by     <= CMAX;
                            r_bz     <= CMAX;
                            r_btag   <= '0;
                        end else begin
                            r_bvalid <= w_nb_valid;
                            r_bdist  <= w_nb_dist;
                            r_bx     <= w_nb_x;
                            r_by     <= w_nb_y;
                            r_bz     <= w_nb_z;
                            r_btag   <= w_nb_tag;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.tri_hit       = r_ohit;
    assign o_res.tri_distance  = r_odist;
    assign o_res.best_found    = r_obfound;
    assign o_res.best_distance = r_obdist;
    assign o_res.best_x        = r_obx;
    assign o_res.best_y        = r_oby;
    assign o_res.best_z        = r_obz;
    assign o_res.best_object   = r_obtag;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == rtch_pkg::ST_ISSUE) && (r_pc == '0))
        else $error("item accepted but sequencer did not start");

    a_update_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rtch_pkg::ST_FIN) && r_upd |-> r_hit)
        else $error("best updated without a hit");

    a_miss_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.tri_hit |-> o_res.tri_distance == CMAX)
        else $error("missed triangle reports a finite distance");

    a_div_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == rtch_pkg::ST_DIV))
        else $error("divider finished outside the division step");

endmodule

>>> src/rtch_mul.sv
module rtch_mul #(
    parameter int FRAC_BITS = rtch_pkg::FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  rtch_pkg::t_ival i_a,
    input  rtch_pkg::t_ival i_b,
    output logic          o_done,
    output rtch_pkg::t_ival o_p
);

    logic           r_busy;
    logic           r_fin;
    logic           r_done;
    logic           r_neg;
    logic [1:0]     r_step;
    logic [63:0]    r_xa;
    logic [63:0]    r_xb;
    logic [127:0]   r_acc;
    rtch_pkg::t_ival r_p;

    logic [31:0]  w_ha;
    logic [31:0]  w_hb;
    logic [63:0]  w_pp;
    logic [6:0]   w_sh;
    logic [127:0] w_pp_sh;
    logic [127:0] w_shift;
    logic [63:0]  w_mag;

    function automatic logic [63:0] mag(input rtch_pkg::t_ival v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    assign w_ha    = r_step[0] ? r_xa[63:32] : r_xa[31:0];
    assign w_hb    = r_step[1] ? r_xb[63:32] : r_xb[31:0];
    assign w_pp    = w_ha * w_hb;
    assign w_sh    = {2'(r_step[0]) + 2'(r_step[1]), 5'b0};
    assign w_pp_sh = {64'b0, w_pp} << w_sh;
    assign w_shift = r_acc >> FRAC_BITS;
    assign w_mag   = (w_shift[127:62] != '0) ? 64'(rtch_pkg::ILIM) : w_shift[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= !i_start && r_busy && (r_step == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
                r_acc  <= '0;
                r_xa   <= mag(i_a);
                r_xb   <= mag(i_b);
                r_neg  <= i_a[63] ^ i_b[63];
            end else if (r_busy) begin
                r_acc  <= r_acc + w_pp_sh;
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
            if (r_fin) begin
                r_p    <= r_neg ? -signed'(w_mag) : signed'(w_mag);
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

>>> src/rtch_div.sv
module rtch_div #(
    parameter int COORD_WIDTH = rtch_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = rtch_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [63:0]                   i_n,
    input  logic [63:0]                   i_d,
    output logic                          o_done,
    output logic signed [COORD_WIDTH-1:0] o_q
);

    localparam int INT_BITS = COORD_WIDTH - 1 - FRAC_BITS;
    localparam int WD       = 64 + INT_BITS;
    localparam int QB       = COORD_WIDTH - 1;
    localparam int CNT_W    = $clog2(QB + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WD-1:0]    r_rem;
    logic [WD-1:0]    r_ds;
    logic [63:0]      r_d;
    logic [QB-1:0]    r_q;

    logic          w_sat;
    logic          w_ph1;
    logic [WD-1:0] w_lhs;
    logic [WD-1:0] w_rhs;
    logic          w_ge;

    assign w_sat = WD'(i_n) >= (WD'(i_d) << INT_BITS);
    assign w_ph1 = r_cnt > CNT_W'(FRAC_BITS);
    assign w_lhs = w_ph1 ? r_rem : (r_rem << 1);
    assign w_rhs = w_ph1 ? r_ds : WD'(r_d);
    assign w_ge  = w_lhs >= w_rhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_start ? w_sat : (r_busy && (r_cnt == CNT_W'(1)));
            if (i_start) begin
                r_d   <= i_d;
                r_rem <= WD'(i_n);
                r_ds  <= WD'(i_d) << (INT_BITS - 1);
                r_cnt <= CNT_W'(QB);
                if (w_sat) begin
                    r_q    <= '1;
                end else begin
                    r_q    <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_lhs - w_rhs) : w_lhs;
                r_ds  <= r_ds >> 1;
                r_q   <= {r_q[QB-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = signed'({1'b0, r_q});

endmodule

>>> tb/rtch_checker.sv
`timescale 1ns / 100ps

module rtch_checker
    import rtch_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    rtch_tri_if                  tri_ch,
    rtch_res_if                  res_ch,
    output int                   o_errors,
    output int                   o_pending
);

    typedef t_ival vec3_t [3];

    typedef struct {
        logic                          hit;
        logic signed [COORD_WIDTH-1:0] tri_dist;
        logic                          found;
        logic signed [COORD_WIDTH-1:0] best_dist;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
        logic signed [COORD_WIDTH-1:0] bz;
        logic [TAG_WIDTH-1:0]          bobj;
    } hit_report_t;

    localparam t_ival COORD_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam t_ival COORD_MIN = -COORD_MAX - 1;

    t_ival       ray_org [3];
    t_ival       ray_dir [3];
    logic [31:0] det_min;

    logic                 near_valid;
    t_ival                near_dist;
    t_ival                near_pt [3];
    logic [TAG_WIDTH-1:0] near_tag;

    hit_report_t pending_reports [$];

    function automatic t_ival fx_mul(input t_ival a, input t_ival b);
        logic [63:0]  x;
        logic [63:0]  y;
        logic [127:0] p;
        logic         neg;
        x   = (a < 0) ? 64'(-a) : 64'(a);
        y   = (b < 0) ? 64'(-b) : 64'(b);
        neg = (a < 0) != (b < 0);
        p   = ({64'd0, x} * {64'd0, y}) >> FRAC_BITS;
        if (p > 128'(ILIM)) begin
            p = 128'(ILIM);
        end
        return neg ? -t_ival'(p[63:0]) : t_ival'(p[63:0]);
    endfunction

    function automatic t_ival fx_add(input t_ival a, input t_ival b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(ILIM)) begin
            return ILIM;
        end
        if (s < -65'(ILIM)) begin
            return -ILIM;
        end
        return t_ival'(s);
    endfunction

    function automatic vec3_t fx_cross(input vec3_t a, input vec3_t b);
        vec3_t c;
        c[0] = fx_add(fx_mul(a[1], b[2]), -fx_mul(a[2], b[1]));
        c[1] = fx_add(fx_mul(a[2], b[0]), -fx_mul(a[0], b[2]));
        c[2] = fx_add(fx_mul(a[0], b[1]), -fx_mul(a[1], b[0]));
        return c;
    endfunction

    function automatic t_ival fx_dot(input vec3_t a, input vec3_t b);
        return fx_add(fx_add(fx_mul(a[0], b[0]), fx_mul(a[1], b[1])), fx_mul(a[2], b[2]));
    endfunction

    function automatic t_ival clamp_coord(input t_ival v);
        return (v > COORD_MAX) ? COORD_MAX : ((v < COORD_MIN) ? COORD_MIN : v);
    endfunction

    function automatic t_ival hit_distance(input logic [63:0] num, input logic [63:0] den);
        logic [127:0] q;
        q = ({64'd0, num} << FRAC_BITS) / {64'd0, den};
        return (q > 128'(COORD_MAX)) ? COORD_MAX : t_ival'(q[63:0]);
    endfunction

    function automatic void clear_nearest();
        near_valid = 1'b0;
        near_dist  = COORD_MAX;
        near_tag   = '0;
        for (int k = 0; k < 3; k++) begin
            near_pt[k] = COORD_MAX;
        end
    endfunction

    function automatic hit_report_t intersect_triangle(input t_ival vtx [9],
                                                       input logic [TAG_WIDTH-1:0] tag,
                                                       input logic eos);
        vec3_t       e1;
        vec3_t       e2;
        vec3_t       tv;
        vec3_t       dv;
        vec3_t       pv;
        vec3_t       qv;
        t_ival       det;
        t_ival       un;
        t_ival       vn;
        t_ival       tn;
        t_ival       t;
        logic [63:0] dm;
        logic        hit;
        hit_report_t r;
        t   = COORD_MAX;
        hit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            e1[k] = vtx[3 + k] - vtx[k];
            e2[k] = vtx[6 + k] - vtx[k];
            tv[k] = ray_org[k] - vtx[k];
            dv[k] = ray_dir[k];
        end
        pv  = fx_cross(dv, e2);
        det = fx_dot(e1, pv);
        dm  = (det < 0) ? 64'(-det) : 64'(det);
        if (det != 0 && dm >= 64'(det_min)) begin
            qv = fx_cross(tv, e1);
            un = fx_dot(tv, pv);
            vn = fx_dot(dv, qv);
            tn = fx_dot(e2, qv);
            if (det < 0) begin
                un = -un;
                vn = -vn;
                tn = -tn;
            end
            if (un >= 0 && 64'(un) <= dm && vn >= 0 && 64'(un + vn) <= dm && tn >= 0) begin
                hit = 1'b1;
                t   = hit_distance(64'(tn), dm);
            end
        end
        if (hit && (!near_valid || t < near_dist)) begin
            near_valid = 1'b1;
            near_dist  = t;
            for (int k = 0; k < 3; k++) begin
                near_pt[k] = clamp_coord(fx_add(ray_org[k], fx_mul(ray_dir[k], t)));
            end
            near_tag = tag;
        end
        r.hit       = hit;
        r.tri_dist  = t[COORD_WIDTH-1:0];
        r.found     = near_valid;
        r.best_dist = near_dist[COORD_WIDTH-1:0];
        r.bx        = near_pt[0][COORD_WIDTH-1:0];
        r.by        = near_pt[1][COORD_WIDTH-1:0];
        r.bz        = near_pt[2][COORD_WIDTH-1:0];
        r.bobj      = near_tag;
        if (eos) begin
            clear_nearest();
        end
        return r;
    endfunction

    function automatic int compare_field(input string name, input logic [63:0] exp_v,
                                         input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        hit_report_t exp_r;
        t_ival       vtx [9];
        int          bad;
        if (!i_rst_n) begin
            ray_org[0] = 0;
            ray_org[1] = 0;
            ray_org[2] = 0;
            ray_dir[0] = 0;
            ray_dir[1] = 0;
            ray_dir[2] = t_ival'(1) <<< FRAC_BITS;
            det_min    = 32'd1;
            clear_nearest();
            pending_reports.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ORIGIN_X: ray_org[0] = t_ival'($signed(i_cfg_data));
                    CFG_ORIGIN_Y: ray_org[1] = t_ival'($signed(i_cfg_data));
                    CFG_ORIGIN_Z: ray_org[2] = t_ival'($signed(i_cfg_data));
                    CFG_DIR_X:    ray_dir[0] = t_ival'($signed(i_cfg_data));
                    CFG_DIR_Y:    ray_dir[1] = t_ival'($signed(i_cfg_data));
                    CFG_DIR_Z:    ray_dir[2] = t_ival'($signed(i_cfg_data));
                    CFG_DET_THR:  det_min    = i_cfg_data;
                    default: ;
                endcase
            end
            bad = 0;
            if (res_ch.valid && res_ch.ready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t unexpected result: expected none actual tri_dist %h",
                             $time, res_ch.tri_distance);
                    bad++;
                end else begin
                    exp_r = pending_reports.pop_front();
                    bad += compare_field("tri_hit", exp_r.hit, res_ch.tri_hit);
                    bad += compare_field("tri_distance", exp_r.tri_dist, res_ch.tri_distance);
                    bad += compare_field("best_found", exp_r.found, res_ch.best_found);
                    bad += compare_field("best_distance", exp_r.best_dist,
                                         res_ch.best_distance);
                    bad += compare_field("best_x", exp_r.bx, res_ch.best_x);
                    bad += compare_field("best_y", exp_r.by, res_ch.best_y);
                    bad += compare_field("best_z", exp_r.bz, res_ch.best_z);
                    bad += compare_field("best_object", exp_r.bobj, res_ch.best_object);
                end
            end
            if (tri_ch.valid && tri_ch.ready) begin
                vtx[0] = t_ival'(tri_ch.v0_x);
                vtx[1] = t_ival'(tri_ch.v0_y);
                vtx[2] = t_ival'(tri_ch.v0_z);
                vtx[3] = t_ival'(tri_ch.v1_x);
                vtx[4] = t_ival'(tri_ch.v1_y);
                vtx[5] = t_ival'(tri_ch.v1_z);
                vtx[6] = t_ival'(tri_ch.v2_x);
                vtx[7] = t_ival'(tri_ch.v2_y);
                vtx[8] = t_ival'(tri_ch.v2_z);
                pending_reports.push_back(intersect_triangle(vtx, tri_ch.object_tag,
                                                             tri_ch.end_of_set));
            end
            o_errors  <= o_errors + bad;
            o_pending <= pending_reports.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import rtch_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int Q          = 65536;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 400;
    localparam int NUM_PHASES = 11;

    typedef struct {
        logic [31:0] v [9];
        logic [7:0]  tag;
        logic        eos;
    } tri_item_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;
    int          idle_cycles;
    int          burst_left;
    int          hold_asks;
    int          hold_seen;
    int          hold_cnt;
    int          rx_cycle;
    int          org [3];
    int          dir [3];

    rtch_tri_if tri_ch ();
    rtch_res_if res_ch ();

    ray_triangle_closest_hit uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_tri     (tri_ch),
        .o_res     (res_ch)
    );

    rtch_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .tri_ch    (tri_ch),
        .res_ch    (res_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_seen    <= 0;
            hold_cnt     <= 0;
            rx_cycle     <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (hold_cnt > 0) begin
                res_ch.ready <= 1'b0;
                hold_cnt     <= hold_cnt - 1;
            end else if (hold_asks != hold_seen) begin
                res_ch.ready <= 1'b0;
                hold_seen    <= hold_asks;
                hold_cnt     <= HOLD_LEN;
            end else begin
                case ((rx_cycle / 97) % 3)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: res_ch.ready <= ((rx_cycle % 8) != 5);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (tri_ch.valid && tri_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_item(input tri_item_t it);
        tri_ch.v0_x       <= it.v[0];
        tri_ch.v0_y       <= it.v[1];
        tri_ch.v0_z       <= it.v[2];
        tri_ch.v1_x       <= it.v[3];
        tri_ch.v1_y       <= it.v[4];
        tri_ch.v1_z       <= it.v[5];
        tri_ch.v2_x       <= it.v[6];
        tri_ch.v2_y       <= it.v[7];
        tri_ch.v2_z       <= it.v[8];
        tri_ch.object_tag <= it.tag;
        tri_ch.end_of_set <= it.eos;
        tri_ch.valid      <= 1'b1;
        do @(posedge i_clk); while (!tri_ch.ready);
        burst_left--;
        if (burst_left <= 0) begin
            tri_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic drain();
        if (tri_ch.valid) begin
            tri_ch.valid <= 1'b0;
        end
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_ray(input int ox, input int oy, input int oz, input int dx,
                           input int dy, input int dz, input logic [31:0] thr);
        org[0] = ox;
        org[1] = oy;
        org[2] = oz;
        dir[0] = dx;
        dir[1] = dy;
        dir[2] = dz;
        cfg_write(CFG_ORIGIN_X, ox);
        cfg_write(CFG_ORIGIN_Y, oy);
        cfg_write(CFG_ORIGIN_Z, oz);
        cfg_write(CFG_DIR_X, dx);
        cfg_write(CFG_DIR_Y, dy);
        cfg_write(CFG_DIR_Z, dz);
        cfg_write(CFG_SPARE, $urandom);
        cfg_write(CFG_DET_THR, thr);
        cfg_we <= 1'b0;
    endtask

    function automatic tri_item_t flat_tri(input int x0, input int y0, input int x1,
                                           input int y1, input int x2, input int y2,
                                           input int z, input logic [7:0] tag,
                                           input logic eos);
        tri_item_t it;
        it.v = '{x0 * Q, y0 * Q, z * Q, x1 * Q, y1 * Q, z * Q, x2 * Q, y2 * Q, z * Q};
        it.tag = tag;
        it.eos = eos;
        return it;
    endfunction

    function automatic tri_item_t rand_tri();
        tri_item_t it;
        longint    p;
        int        t0;
        int        kind;
        kind = $urandom_range(0, 99);
        t0 = (kind < 65) ? $urandom_range(0, 40) : -$urandom_range(1, 40);
        for (int j = 0; j < 9; j++) begin
            p = longint'(org[j % 3]) + longint'(dir[j % 3]) * t0;
            p = p + $signed($urandom_range(0, 16 * Q)) - 8 * Q;
            p = (p > 64'sh7FFFFFFF) ? 64'sh7FFFFFFF : ((p < -64'sh80000000) ? -64'sh80000000 : p);
            it.v[j] = p[31:0];
        end
        if (kind >= 80 && kind < 90) begin
            for (int j = 0; j < 3; j++) begin
                it.v[3 + j] = it.v[j];
            end
        end else if (kind >= 90) begin
            for (int j = 0; j < 9; j++) begin
                it.v[j] = $urandom;
            end
        end
        it.tag = $urandom_range(0, 255);
        it.eos = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    initial begin
        tri_item_t it;
        int        n_items;
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= '0;
        cfg_data     <= '0;
        tri_ch.valid <= 1'b0;
        tri_ch.v0_x  <= '0;
        tri_ch.v0_y  <= '0;
        tri_ch.v0_z  <= '0;
        tri_ch.v1_x  <= '0;
        tri_ch.v1_y  <= '0;
        tri_ch.v1_z  <= '0;
        tri_ch.v2_x  <= '0;
        tri_ch.v2_y  <= '0;
        tri_ch.v2_z  <= '0;
        tri_ch.object_tag <= '0;
        tri_ch.end_of_set <= 1'b0;
        hold_asks    <= 0;
        org          = '{0, 0, 0};
        dir          = '{0, 0, Q};
        burst_left   = $urandom_range(1, 40);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_item(flat_tri(-1, -1, 3, -1, -1, 3, 5, 8'd1, 1'b0));
        push_item(flat_tri(-1, -1, 3, -1, -1, 3, 5, 8'd2, 1'b0));
        push_item(flat_tri(-1, -1, 3, -1, -1, 3, 3, 8'd3, 1'b0));
        push_item(flat_tri(-1, -1, 3, -1, -1, 3, 8, 8'd4, 1'b0));
        push_item(flat_tri(-1, -1, 3, -1, -1, 3, -2, 8'd5, 1'b0));
        push_item(flat_tri(-1, -1, -1, -1, 3, 3, 2, 8'd6, 1'b0));
        push_item(flat_tri(10, 10, 14, 10, 10, 14, 4, 8'd7, 1'b0));
        push_item(flat_tri(-1, -1, -1, 3, 3, -1, 2, 8'd255, 1'b0));
        push_item(flat_tri(0, 0, 4, 0, 0, 4, 6, 8'd0, 1'b1));
        it.v = '{9{32'h7FFFFFFF}};
        it.tag = 8'd0;
        it.eos = 1'b0;
        push_item(it);
        it.v = '{9{32'h80000000}};
        it.tag = 8'd255;
        push_item(it);
        it.v = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
        it.eos = 1'b1;
        push_item(it);

        for (int ph = 1; ph < NUM_PHASES; ph++) begin
            drain();
            n_items = 70;
            case (ph)
                1: set_ray(Q, 2 * Q, -3 * Q, Q, Q / 2, 2 * Q, 32'd0);
                2: begin
                    set_ray(32'h80000000, 32'h80000000, 32'h80000000,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
                    n_items = 30;
                end
                3: begin
                    set_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            32'h80000000, 32'h80000000, 32'h80000000, 32'd0);
                    n_items = 30;
                end
                4: begin
                    set_ray(0, 0, 0, 0, 0, 1, 32'd1);
                    push_item(flat_tri(-1, -1, 3, -1, -1, 3, 5, 8'd9, 1'b0));
                    push_item(flat_tri(-1, -1, 3, -1, -1, 3, 4, 8'd10, 1'b1));
                    n_items = 30;
                end
                5: begin
                    set_ray(0, 0, 0, 0, 0, Q, 32'hFFFFFFFF);
                    push_item(flat_tri(-1, -1, 3, -1, -1, 3, 5, 8'd11, 1'b1));
                    drain();
                    set_ray(0, 0, 0, 0, 0, Q, 32'd0);
                    push_item(flat_tri(-1, -1, -1, -1, 3, 3, 2, 8'd12, 1'b1));
                end
                default: set_ray($signed($urandom_range(0, 200 * Q)) - 100 * Q,
                                 $signed($urandom_range(0, 200 * Q)) - 100 * Q,
                                 $signed($urandom_range(0, 200 * Q)) - 100 * Q,
                                 $signed($urandom_range(0, 8 * Q)) - 4 * Q,
                                 $signed($urandom_range(0, 8 * Q)) - 4 * Q,
                                 $signed($urandom_range(0, 8 * Q)) - 4 * Q,
                                 $urandom_range(0, 4));
            endcase
            if (ph == 1) begin
                hold_asks <= hold_asks + 1;
            end
            for (int k = 0; k < n_items; k++) begin
                if (ph == 6 && k == 35) begin
                    drain();
                end
                push_item(rand_tri());
            end
        end

        drain();
        repeat (250) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
src/rtch_pkg.sv
src/rtch_tri_if.sv
src/rtch_res_if.sv
src/rtch_mul.sv
src/rtch_div.sv
src/ray_triangle_closest_hit.sv
tb/rtch_checker.sv
tb/tb_top.sv
